/* design/mprsm_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mprsm_pkg
// Shared types, codes and helpers for the picture reference slot manager.
// ----------------------------------------------------------------------------
package mprsm_pkg;

    // Slot codes.
    localparam logic [2:0] SLOT_NONE    = 3'd0;
    localparam logic [2:0] SLOT_A1      = 3'd1;
    localparam logic [2:0] SLOT_A2      = 3'd2;
    localparam logic [2:0] SLOT_B       = 3'd3;
    localparam logic [2:0] SLOT_DROP_IP = 3'd4;
    localparam logic [2:0] SLOT_DROP_B  = 3'd5;

    // Result status codes.
    localparam logic [3:0] ST_PIC_OK      = 4'd0;
    localparam logic [3:0] ST_PIC_SKIP    = 4'd1;
    localparam logic [3:0] ST_SLICE_DEC   = 4'd2;
    localparam logic [3:0] ST_SLICE_DROP  = 4'd3;
    localparam logic [3:0] ST_EXT_OK      = 4'd4;
    localparam logic [3:0] ST_EXT_REJECT  = 4'd5;
    localparam logic [3:0] ST_UNKNOWN     = 4'd6;
    localparam logic [3:0] ST_PRESENTED   = 4'd7;
    localparam logic [3:0] ST_NOT_PRESENT = 4'd8;

    // Picture coding types.
    localparam logic [2:0] PTYPE_I = 3'd1;
    localparam logic [2:0] PTYPE_P = 3'd2;
    localparam logic [2:0] PTYPE_B = 3'd3;

    // Opcodes and start codes.
    localparam logic       OP_PACKET   = 1'b0;
    localparam logic       OP_EMIT     = 1'b1;
    localparam logic [7:0] SC_PICTURE  = 8'h00;
    localparam logic [7:0] SC_SLICE_HI = 8'hAF;
    localparam logic [7:0] SC_EXT      = 8'hB5;
    localparam logic [3:0] EXT_PIC_CODING = 4'h8;

    // Configuration register indexes.
    localparam logic [1:0] CFG_DROP_LEVEL = 2'd0;
    localparam logic [1:0] CFG_ALLOW_B    = 2'd1;
    localparam logic [1:0] CFG_MPEG2      = 2'd2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 2;

    typedef struct packed {
        logic [1:0] drop_level;
        logic       allow_b;
        logic       mpeg2;
    } t_cfg;

    typedef struct packed {
        logic [2:0] cur_slot;
        logic [2:0] fwd_slot;
        logic [2:0] bwd_slot;
        logic [2:0] show_slot;
        logic       ext_allowed;
        logic [9:0] tref;
        logic [2:0] ptype;
        logic [3:0] fh_code;
        logic [3:0] fv_code;
        logic [3:0] bh_code;
        logic [3:0] bv_code;
        logic [1:0] full_pel;
    } t_state;

    typedef struct packed {
        logic [3:0] status;
        logic [2:0] cur_slot;
        logic [2:0] fwd_slot;
        logic [2:0] bwd_slot;
        logic [2:0] present_slot;
        logic [2:0] ptype;
        logic [9:0] tref;
        logic [3:0] fh_code;
        logic [3:0] fv_code;
        logic [3:0] bh_code;
        logic [3:0] bv_code;
        logic [1:0] full_pel;
    } t_result;

    function automatic logic [2:0] other_anchor(input logic [2:0] s);
        return (s == SLOT_A1) ? SLOT_A2 : SLOT_A1;
    endfunction

    // A code of zero stays zero, otherwise it is stored minus one.
    function automatic logic [3:0] code_dec4(input logic [3:0] c);
        return (c == 4'd0) ? 4'd0 : c - 4'd1;
    endfunction

    function automatic logic is_dropped(input logic [2:0] s);
        return (s == SLOT_DROP_IP) || (s == SLOT_DROP_B);
    endfunction

endpackage
`default_nettype wire

/* design/mprsm_step.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mprsm_step
// Combinational next-state and result logic for one event.
// ----------------------------------------------------------------------------
module mprsm_step (
    input  wire mprsm_pkg::t_state  i_state,
    input  wire mprsm_pkg::t_cfg    i_cfg,
    input  wire logic               i_opcode,
    input  wire logic [7:0]         i_start_code,
    input  wire logic [39:0]        i_header_bits,
    output mprsm_pkg::t_state       o_state,
    output mprsm_pkg::t_result      o_result
);

    always_comb begin
        mprsm_pkg::t_state n;
        logic [3:0] status;
        logic [2:0] ptype;
        logic [2:0] slot;
        logic [2:0] anchor;
        logic       drop;
        logic       refs_ok;

        n      = i_state;
        status = mprsm_pkg::ST_UNKNOWN;
        ptype  = i_header_bits[29:27];
        slot   = mprsm_pkg::SLOT_NONE;
        anchor = mprsm_pkg::SLOT_NONE;
        drop   = 1'b0;

        refs_ok = 1'b1;
        if (ptype == mprsm_pkg::PTYPE_B) begin
            refs_ok = (i_state.fwd_slot != mprsm_pkg::SLOT_NONE) &&
                      (i_state.bwd_slot != mprsm_pkg::SLOT_NONE);
        end else if (ptype == mprsm_pkg::PTYPE_P) begin
            refs_ok = (i_state.fwd_slot != mprsm_pkg::SLOT_NONE);
        end else if (ptype != mprsm_pkg::PTYPE_I) begin
            refs_ok = 1'b0;
        end

        if (i_opcode == mprsm_pkg::OP_EMIT) begin
            status = mprsm_pkg::is_dropped(i_state.cur_slot) ?
                     mprsm_pkg::ST_NOT_PRESENT : mprsm_pkg::ST_PRESENTED;
            // After a B picture is shown, display falls back to the past anchor.
            if (i_state.show_slot == mprsm_pkg::SLOT_B ||
                i_state.show_slot == mprsm_pkg::SLOT_DROP_B) begin
                n.show_slot = i_state.bwd_slot;
            end
        end else if (i_start_code == mprsm_pkg::SC_PICTURE) begin
            n.ext_allowed = 1'b0;
            n.tref        = i_header_bits[39:30];
            n.ptype       = ptype;
            if (!refs_ok) begin
                status = mprsm_pkg::ST_PIC_SKIP;
            end else begin
                status        = mprsm_pkg::ST_PIC_OK;
                n.ext_allowed = i_cfg.mpeg2;
                if (ptype != mprsm_pkg::PTYPE_I) begin
                    n.full_pel[0] = i_header_bits[10];
                    n.fh_code     = mprsm_pkg::code_dec4({1'b0, i_header_bits[9:7]});
                    n.fv_code     = mprsm_pkg::code_dec4({1'b0, i_header_bits[9:7]});
                end
                case (ptype)
                    mprsm_pkg::PTYPE_B: begin
                        n.full_pel[1] = i_header_bits[6];
                        n.bh_code     = mprsm_pkg::code_dec4({1'b0, i_header_bits[5:3]});
                        n.bv_code     = mprsm_pkg::code_dec4({1'b0, i_header_bits[5:3]});
                        slot = (i_cfg.drop_level == 2'd0 && i_cfg.allow_b) ?
                               mprsm_pkg::SLOT_B : mprsm_pkg::SLOT_DROP_B;
                        n.cur_slot  = slot;
                        n.show_slot = slot;
                    end
                    mprsm_pkg::PTYPE_I: begin
                        drop = (i_cfg.drop_level == 2'd3);
                        if (i_state.fwd_slot == mprsm_pkg::SLOT_NONE) begin
                            slot = drop ? mprsm_pkg::SLOT_DROP_IP : mprsm_pkg::SLOT_A1;
                            n.cur_slot  = slot;
                            n.fwd_slot  = slot;
                            n.show_slot = slot;
                        end else begin
                            anchor = (i_state.bwd_slot != mprsm_pkg::SLOT_NONE) ?
                                     i_state.bwd_slot : i_state.fwd_slot;
                            slot = drop ? mprsm_pkg::SLOT_DROP_IP :
                                   mprsm_pkg::other_anchor(anchor);
                            n.fwd_slot  = anchor;
                            n.cur_slot  = slot;
                            n.bwd_slot  = slot;
                            n.show_slot = slot;
                        end
                    end
                    default: begin
                        // P picture.
                        drop = (i_cfg.drop_level >= 2'd2);
                        if (i_state.fwd_slot == mprsm_pkg::SLOT_DROP_IP) begin
                            n.cur_slot = mprsm_pkg::SLOT_DROP_IP;
                            n.fwd_slot = mprsm_pkg::SLOT_DROP_IP;
                            n.bwd_slot = mprsm_pkg::SLOT_DROP_IP;
                        end else if (i_state.bwd_slot == mprsm_pkg::SLOT_NONE) begin
                            slot = drop ? mprsm_pkg::SLOT_DROP_IP :
                                   mprsm_pkg::other_anchor(i_state.fwd_slot);
                            n.cur_slot  = slot;
                            n.bwd_slot  = slot;
                            n.show_slot = slot;
                        end else begin
                            anchor = i_state.bwd_slot;
                            slot = (drop || anchor == mprsm_pkg::SLOT_DROP_IP) ?
                                   mprsm_pkg::SLOT_DROP_IP :
                                   mprsm_pkg::other_anchor(anchor);
                            n.fwd_slot  = anchor;
                            n.cur_slot  = slot;
                            n.bwd_slot  = slot;
                            n.show_slot = slot;
                        end
                    end
                endcase
            end
        end else if (i_start_code <= mprsm_pkg::SC_SLICE_HI) begin
            status = mprsm_pkg::is_dropped(i_state.cur_slot) ?
                     mprsm_pkg::ST_SLICE_DROP : mprsm_pkg::ST_SLICE_DEC;
        end else if (i_start_code == mprsm_pkg::SC_EXT) begin
            if (i_header_bits[39:36] == mprsm_pkg::EXT_PIC_CODING &&
                i_state.ext_allowed) begin
                status        = mprsm_pkg::ST_EXT_OK;
                n.fh_code     = mprsm_pkg::code_dec4(i_header_bits[35:32]);
                n.fv_code     = mprsm_pkg::code_dec4(i_header_bits[31:28]);
                n.bh_code     = mprsm_pkg::code_dec4(i_header_bits[27:24]);
                n.bv_code     = mprsm_pkg::code_dec4(i_header_bits[23:20]);
                n.ext_allowed = 1'b0;
            end else begin
                status = mprsm_pkg::ST_EXT_REJECT;
            end
        end

        o_state = n;

        o_result.status       = status;
        o_result.cur_slot     = n.cur_slot;
        o_result.fwd_slot     = n.fwd_slot;
        o_result.bwd_slot     = n.bwd_slot;
        o_result.present_slot = (i_opcode == mprsm_pkg::OP_EMIT) ?
                                i_state.show_slot : n.show_slot;
        o_result.ptype        = n.ptype;
        o_result.tref         = n.tref;
        o_result.fh_code      = n.fh_code;
        o_result.fv_code      = n.fv_code;
        o_result.bh_code      = n.bh_code;
        o_result.bv_code      = n.bv_code;
        o_result.full_pel     = n.full_pel;
    end

endmodule
`default_nettype wire

/* design/mpeg_picture_reference_slot_manager.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mpeg_picture_reference_slot_manager
// Tracks anchor, B and display slots from picture, slice, extension and emit
// events of an MPEG-1/MPEG-2 video stream.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake                        Payload
//  -------  -------------------------------  -------------------------------
//  input    i_in_valid / o_in_ready          opcode, start code, 40 header bits
//  output   o_out_valid / i_out_ready        status, four slots, picture fields
//  config   i_cfg_we (no wait, no readback)  i_cfg_index, i_cfg_data
//
// Each word is captured in an input register, processed by one stage of
// shallow logic, and written to a result register together with the slot
// state; a word is accepted every cycle unless the result register stalls,
// and its result is shown on the outputs from the result register.
// A stalled result register holds its word and stops the input stage;
// the input register still takes one more word while a result waits.
// Reset is synchronous, active low, and clears the valid flags, the slot state
// and the configuration registers (allow_b resets to 1).
//
module mpeg_picture_reference_slot_manager (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Input channel
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic        i_opcode,
    input  wire logic [7:0]  i_start_code,
    input  wire logic [39:0] i_header_bits,
    // Output channel
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [3:0]       o_status,
    output logic [2:0]       o_current_slot,
    output logic [2:0]       o_future_slot,
    output logic [2:0]       o_past_slot,
    output logic [2:0]       o_present_slot,
    output logic [2:0]       o_picture_type,
    output logic [9:0]       o_temporal_ref,
    output logic [3:0]       o_forward_h_code,
    output logic [3:0]       o_forward_v_code,
    output logic [3:0]       o_backward_h_code,
    output logic [3:0]       o_backward_v_code,
    output logic [1:0]       o_full_pel_flags,
    // Configuration port
    input  wire logic                             i_cfg_we,
    input  wire logic [mprsm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [mprsm_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    // Configuration registers.
    mprsm_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.drop_level <= 2'd0;
            r_cfg.allow_b    <= 1'b1;
            r_cfg.mpeg2      <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                mprsm_pkg::CFG_DROP_LEVEL: r_cfg.drop_level <= i_cfg_data[1:0];
                mprsm_pkg::CFG_ALLOW_B:    r_cfg.allow_b    <= i_cfg_data[0];
                mprsm_pkg::CFG_MPEG2:      r_cfg.mpeg2      <= i_cfg_data[0];
                default: ;  // Indexes past the register list are ignored.
            endcase
        end
    end

    // Input register.
    logic        r_in_vld;
    logic        r_in_op;
    logic [7:0]  r_in_sc;
    logic [39:0] r_in_hdr;

    // Result register and slot state.
    logic                 r_out_vld;
    mprsm_pkg::t_result   r_res;
    mprsm_pkg::t_state    r_st;

    mprsm_pkg::t_state    n_st;
    mprsm_pkg::t_result   n_res;
    logic                 advance;

    // The input word moves into the result register whenever that register
    // is empty or its word is being taken this cycle.
    assign advance    = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_op  <= i_opcode;
            r_in_sc  <= i_start_code;
            r_in_hdr <= i_header_bits;
        end
    end

    mprsm_step u_step (
        .i_state       (r_st),
        .i_cfg         (r_cfg),
        .i_opcode      (r_in_op),
        .i_start_code  (r_in_sc),
        .i_header_bits (r_in_hdr),
        .o_state       (n_st),
        .o_result      (n_res)
    );

    // The slot state commits in the same cycle the result is registered, so
    // the next word in the input register already sees it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st      <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (advance) begin
                r_st <= n_st;
            end
            if (advance) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid       = r_out_vld;
    assign o_status          = r_res.status;
    assign o_current_slot    = r_res.cur_slot;
    assign o_future_slot     = r_res.fwd_slot;
    assign o_past_slot       = r_res.bwd_slot;
    assign o_present_slot    = r_res.present_slot;
    assign o_picture_type    = r_res.ptype;
    assign o_temporal_ref    = r_res.tref;
    assign o_forward_h_code  = r_res.fh_code;
    assign o_forward_v_code  = r_res.fv_code;
    assign o_backward_h_code = r_res.bh_code;
    assign o_backward_v_code = r_res.bv_code;
    assign o_full_pel_flags  = r_res.full_pel;

`ifndef SYNTH
    // A word that leaves the input register always shows up as a result.
    a_advance_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> o_out_valid)
        else $error("result register not loaded after advance");

    // A taken input word lands in the input register.
    a_input_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_in_vld)
        else $error("accepted word lost at input register");

    // A past anchor is never set without a future anchor.
    a_anchor_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st.fwd_slot == mprsm_pkg::SLOT_NONE) |->
        (r_st.bwd_slot == mprsm_pkg::SLOT_NONE))
        else $error("past slot set without future slot");

    // An accepted extension closes the window.
    a_ext_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && n_res.status == mprsm_pkg::ST_EXT_OK) |=> !r_st.ext_allowed)
        else $error("extension window still open after accepted extension");

    // Current and present slot codes in a shown result stay within the defined set.
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_current_slot <= mprsm_pkg::SLOT_DROP_B &&
                         o_present_slot <= mprsm_pkg::SLOT_DROP_B))
        else $error("slot code out of range");
`endif

endmodule
`default_nettype wire
